### design/pidc_pkg.sv
`timescale 1ns / 1ps

package pidc_pkg;

	localparam int DW    = 32;
	localparam int FRAC  = 16;
	localparam int TS_W  = 31;
	localparam int NUM_W = DW + FRAC;
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam int IDX_W = 3;
	localparam int IN_W  = 3 * DW;

	typedef logic signed [DW-1:0] q_t;

	localparam q_t Q_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam q_t Q_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam q_t Q_ONE = q_t'(1) <<< FRAC;
	localparam q_t Q_NEG_ONE = -Q_ONE;

	localparam logic OP_STEP = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	typedef enum logic [IDX_W-1:0] {
		REG_TIME_STEP  = 3'd0,
		REG_OUTPUT_MAX = 3'd1,
		REG_OUTPUT_MIN = 3'd2,
		REG_GAIN_P     = 3'd3,
		REG_GAIN_D     = 3'd4,
		REG_GAIN_I     = 3'd5
	} reg_idx_t;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_MUL_P  = 10'b00_0000_0010,
		ST_MUL_E  = 10'b00_0000_0100,
		ST_ADD_I  = 10'b00_0000_1000,
		ST_MUL_I  = 10'b00_0001_0000,
		ST_ACC_I  = 10'b00_0010_0000,
		ST_WAIT_D = 10'b00_0100_0000,
		ST_MUL_D  = 10'b00_1000_0000,
		ST_ACC_D  = 10'b01_0000_0000,
		ST_OUT    = 10'b10_0000_0000
	} state_t;

	function automatic q_t sat_add(input q_t a, input q_t b);
		logic signed [DW:0] s;
		s = {a[DW-1], a} + {b[DW-1], b};
		if (s[DW] != s[DW-1])
			return s[DW] ? Q_MIN : Q_MAX;
		return s[DW-1:0];
	endfunction

	function automatic q_t sat_sub(input q_t a, input q_t b);
		logic signed [DW:0] s;
		s = {a[DW-1], a} - {b[DW-1], b};
		if (s[DW] != s[DW-1])
			return s[DW] ? Q_MIN : Q_MAX;
		return s[DW-1:0];
	endfunction

endpackage

### design/pid_controller_clamped.sv
`timescale 1ns / 1ps
// PID controller step, signed Q16.16, integral clamped to +/-1.
// Input channel s_*: one word per operation. s_tuser selects the operation:
//   0 runs a control step on target/measured and yields one drive word,
//   1 loads the integral from new_integral and yields nothing.
// Output channel m_*: m_tdata carries the clamped drive value.
// Config port: cfg_we/cfg_index/cfg_data write time_step, output_max, output_min,
// gain_p, gain_d, gain_i (index 0..5). The user writes them only while the block
// is idle; the block does not enforce it. A control step is dominated by the
// derivative divide: a restoring divider that retires one quotient bit per
// cycle over 48 bits, run alongside a single shared 32x32 multiplier that
// forms the P, integral, I and D products in turn. s_tready is high only
// while the sequencer is idle, so one step is in flight at a time and no new
// word is taken until the step's result has moved into the output register.
// The result sits in an output register; a new word is accepted while it
// waits. If m_tready is low when the next result is ready, the sequencer
// holds until the register frees up.
// Reset (arst_n low) restores the default registers, clears the integral and
// the previous error, and drops m_tvalid.

module pid_controller_clamped (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pidc_pkg::IN_W-1:0]     s_tdata,  // target, measured, new_integral
	input  logic [0:0]                    s_tuser,  // opcode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pidc_pkg::DW-1:0]       m_tdata,  // drive
	input  logic                          cfg_we,
	input  logic [pidc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [pidc_pkg::DW-1:0]       cfg_data
);

	pidc_pkg::state_t          state_q;
	logic [pidc_pkg::TS_W-1:0] time_step_q;
	pidc_pkg::q_t              max_q;
	pidc_pkg::q_t              min_q;
	pidc_pkg::q_t              kp_q;
	pidc_pkg::q_t              kd_q;
	pidc_pkg::q_t              ki_q;
	pidc_pkg::q_t              integral_q;
	pidc_pkg::q_t              prev_err_q;
	pidc_pkg::q_t              err_q;
	pidc_pkg::q_t              acc_q;
	pidc_pkg::q_t              out_q;
	logic                      out_vld_q;

	pidc_pkg::q_t              target;
	pidc_pkg::q_t              measured;
	pidc_pkg::q_t              new_integral;
	pidc_pkg::q_t              mul_a;
	pidc_pkg::q_t              mul_b;
	pidc_pkg::q_t              mul_res;
	pidc_pkg::q_t              div_diff;
	pidc_pkg::q_t              deriv;
	pidc_pkg::q_t              acc_sum;
	logic                      div_start;
	logic                      div_done;
	logic                      accept;
	logic                      out_free;

	assign target       = s_tdata[pidc_pkg::DW-1:0];
	assign measured     = s_tdata[2*pidc_pkg::DW-1:pidc_pkg::DW];
	assign new_integral = s_tdata[3*pidc_pkg::DW-1:2*pidc_pkg::DW];

	assign s_tready  = (state_q == pidc_pkg::ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_vld_q || m_tready;
	assign div_start = (state_q == pidc_pkg::ST_MUL_P);
	assign div_diff  = pidc_pkg::sat_sub(err_q, prev_err_q);
	assign acc_sum   = pidc_pkg::sat_add(acc_q, mul_res);

	always_comb begin
		case (state_q)
			pidc_pkg::ST_MUL_P: begin
				mul_a = kp_q;
				mul_b = err_q;
			end
			pidc_pkg::ST_MUL_E: begin
				mul_a = err_q;
				mul_b = pidc_pkg::q_t'({1'b0, time_step_q});
			end
			pidc_pkg::ST_MUL_I: begin
				mul_a = ki_q;
				mul_b = integral_q;
			end
			pidc_pkg::ST_MUL_D: begin
				mul_a = kd_q;
				mul_b = deriv;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	pidc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.q   (mul_res)
	);

	pidc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.diff    (div_diff),
		.divisor (time_step_q),
		.done    (div_done),
		.quot    (deriv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= pidc_pkg::TS_W'(655);
			max_q       <= pidc_pkg::Q_ONE;
			min_q       <= pidc_pkg::Q_NEG_ONE;
			kp_q        <= pidc_pkg::Q_ONE;
			kd_q        <= '0;
			ki_q        <= '0;
		end else if (cfg_we) begin
			case (pidc_pkg::reg_idx_t'(cfg_index))
				pidc_pkg::REG_TIME_STEP:  time_step_q <= cfg_data[pidc_pkg::TS_W-1:0];
				pidc_pkg::REG_OUTPUT_MAX: max_q <= cfg_data;
				pidc_pkg::REG_OUTPUT_MIN: min_q <= cfg_data;
				pidc_pkg::REG_GAIN_P:     kp_q <= cfg_data;
				pidc_pkg::REG_GAIN_D:     kd_q <= cfg_data;
				pidc_pkg::REG_GAIN_I:     ki_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pidc_pkg::ST_IDLE;
			integral_q <= '0;
			prev_err_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_vld_q && m_tready && (state_q != pidc_pkg::ST_OUT))
				out_vld_q <= 1'b0;
			case (state_q)
				pidc_pkg::ST_IDLE: begin
					if (accept) begin
						if (s_tuser[0] == pidc_pkg::OP_LOAD)
							integral_q <= new_integral;
						else
							state_q <= pidc_pkg::ST_MUL_P;
					end
				end
				pidc_pkg::ST_MUL_P: begin
					prev_err_q <= err_q;
					state_q    <= pidc_pkg::ST_MUL_E;
				end
				pidc_pkg::ST_MUL_E: state_q <= pidc_pkg::ST_ADD_I;
				pidc_pkg::ST_ADD_I: begin
					integral_q <= pidc_pkg::sat_add(integral_q, mul_res);
					state_q    <= pidc_pkg::ST_MUL_I;
				end
				pidc_pkg::ST_MUL_I: state_q <= pidc_pkg::ST_ACC_I;
				pidc_pkg::ST_ACC_I: begin
					if (integral_q > pidc_pkg::Q_ONE)
						integral_q <= pidc_pkg::Q_ONE;
					else if (integral_q < pidc_pkg::Q_NEG_ONE)
						integral_q <= pidc_pkg::Q_NEG_ONE;
					state_q <= pidc_pkg::ST_WAIT_D;
				end
				pidc_pkg::ST_WAIT_D: begin
					if (div_done)
						state_q <= pidc_pkg::ST_MUL_D;
				end
				pidc_pkg::ST_MUL_D: state_q <= pidc_pkg::ST_ACC_D;
				pidc_pkg::ST_ACC_D: state_q <= pidc_pkg::ST_OUT;
				pidc_pkg::ST_OUT: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						state_q   <= pidc_pkg::ST_IDLE;
					end
				end
				default: state_q <= pidc_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			err_q <= pidc_pkg::sat_sub(target, measured);
		case (state_q)
			pidc_pkg::ST_MUL_E: acc_q <= mul_res;
			pidc_pkg::ST_ACC_I: acc_q <= acc_sum;
			pidc_pkg::ST_ACC_D: acc_q <= acc_sum;
			pidc_pkg::ST_OUT: begin
				if (out_free) begin
					if (acc_q > max_q)
						out_q <= max_q;
					else if (acc_q < min_q)
						out_q <= min_q;
					else
						out_q <= acc_q;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

`ifndef SYNTHESIS
	a_int_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pidc_pkg::ST_ACC_I) |=>
		(integral_q <= pidc_pkg::Q_ONE && integral_q >= pidc_pkg::Q_NEG_ONE))
		else $error("integral outside +/-1 after clamp");

	a_div_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pidc_pkg::ST_MUL_D) |-> div_done)
		else $error("derivative used before divide finished");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_vld_q) && min_q <= max_q) |->
		(out_q <= max_q && out_q >= min_q))
		else $error("drive outside output clamp");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !m_tready) |=> $stable(out_q))
		else $error("pending drive word overwritten");
`endif

endmodule

### design/pidc_mul.sv
`timescale 1ns / 1ps

module pidc_mul (
	input  logic          clk,
	input  pidc_pkg::q_t  a,
	input  pidc_pkg::q_t  b,
	output pidc_pkg::q_t  q
);

	logic signed [2*pidc_pkg::DW-1:0] prod_s1;
	logic                             over;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	// floor shift by FRAC, then saturate to DW bits
	assign over = !((&prod_s1[2*pidc_pkg::DW-1:pidc_pkg::DW+pidc_pkg::FRAC-1]) ||
		(~|prod_s1[2*pidc_pkg::DW-1:pidc_pkg::DW+pidc_pkg::FRAC-1]));

	always_comb begin
		if (over)
			q = prod_s1[2*pidc_pkg::DW-1] ? pidc_pkg::Q_MIN : pidc_pkg::Q_MAX;
		else
			q = prod_s1[pidc_pkg::DW+pidc_pkg::FRAC-1:pidc_pkg::FRAC];
	end

endmodule

### design/pidc_div.sv
`timescale 1ns / 1ps

module pidc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  pidc_pkg::q_t               diff,
	input  logic [pidc_pkg::TS_W-1:0]  divisor,
	output logic                       done,
	output pidc_pkg::q_t               quot
);

	logic [pidc_pkg::NUM_W-1:0] work_q;
	logic [pidc_pkg::TS_W-1:0]  rem_q;
	logic [pidc_pkg::TS_W-1:0]  dvs_q;
	logic [pidc_pkg::CNT_W-1:0] cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic                       neg_q;
	logic                       zero_q;

	logic [pidc_pkg::DW-1:0]    mag;
	logic [pidc_pkg::TS_W:0]    rem_sh;
	logic [pidc_pkg::TS_W+1:0]  trial;
	logic                       fits;

	assign mag    = diff[pidc_pkg::DW-1] ? (pidc_pkg::DW'(0) - diff) : diff;
	assign rem_sh = {rem_q, work_q[pidc_pkg::NUM_W-1]};
	assign trial  = {1'b0, rem_sh} - {2'b00, dvs_q};
	assign fits   = !trial[pidc_pkg::TS_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= pidc_pkg::CNT_W'(pidc_pkg::NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == pidc_pkg::CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= {mag, {pidc_pkg::FRAC{1'b0}}};
			rem_q  <= '0;
			dvs_q  <= divisor;
			neg_q  <= diff[pidc_pkg::DW-1];
			zero_q <= (divisor == '0);
		end else if (busy_q) begin
			work_q <= {work_q[pidc_pkg::NUM_W-2:0], fits};
			rem_q  <= fits ? trial[pidc_pkg::TS_W-1:0] : rem_sh[pidc_pkg::TS_W-1:0];
		end
	end

	always_comb begin
		if (zero_q)
			quot = '0;
		else if (neg_q) begin
			if ((|work_q[pidc_pkg::NUM_W-1:pidc_pkg::DW]) ||
				(work_q[pidc_pkg::DW-1] && (|work_q[pidc_pkg::DW-2:0])))
				quot = pidc_pkg::Q_MIN;
			else
				quot = pidc_pkg::DW'(0) - work_q[pidc_pkg::DW-1:0];
		end else begin
			if (|work_q[pidc_pkg::NUM_W-1:pidc_pkg::DW-1])
				quot = pidc_pkg::Q_MAX;
			else
				quot = work_q[pidc_pkg::DW-1:0];
		end
	end

	assign done = done_q;

endmodule
